/* rtl/sbli_pkg.sv */
// Shared types, codes and constants for the sorted breakpoint interpolation unit.
// No dependencies; every other file except sbli_ram imports this package.
package sbli_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int DATA_W         = 32;
   localparam int POINT_W        = 7;
   localparam int STATUS_W       = 2;
   localparam int OP_W           = 2;

   // request opcodes
   localparam logic [OP_W-1:0] OP_EVAL   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd2;

   // table read address select
   localparam logic [2:0] RA_MID  = 3'd0;  // search probe
   localparam logic [2:0] RA_PREV = 3'd1;  // entry below the upper index (or entry 0)
   localparam logic [2:0] RA_CUR  = 3'd2;  // upper index
   localparam logic [2:0] RA_SDN  = 3'd3;  // shift pointer minus one
   localparam logic [2:0] RA_SUP  = 3'd4;  // shift pointer plus one
   localparam logic [2:0] RA_TOP  = 3'd5;  // last held entry

   // table write address select
   localparam logic [1:0] WA_PREV = 2'd0;
   localparam logic [1:0] WA_CUR  = 2'd1;
   localparam logic [1:0] WA_SUP  = 2'd2;
   localparam logic [1:0] WA_SDN  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       clr_cnt;
      logic       set_short;
      logic       set_full;
      logic       srch_rd;
      logic       srch_cmp;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       cap0;
      logic       take_v0;
      logic       prep;
      logic       mul;
      logic       div_start;
      logic       fin;
      logic       key_we;
      logic       val_we;
      logic [1:0] wa_sel;
      logic       wd_mem;
      logic       s_load_top;
      logic       s_load_i;
      logic       s_dec;
      logic       s_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            short_tbl;
      logic            full;
      logic            srch_done;
      logic            i_zero;
      logic            i_end;
      logic            match;
      logic            s_at_i;
      logic            s_at_top;
      logic            div_busy;
      logic            rsp_full;
   } stat_type;

endpackage

/* rtl/sbli_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbli_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sbli_div.sv */
// Bit-serial unsigned divider, 64-bit dividend by 32-bit divisor, 32 quotient bits.
// Depends on sbli_pkg. Caller guarantees the quotient fits in 32 bits.
module sbli_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [2*sbli_pkg::DATA_W-1:0]    dividend,
   input  logic [sbli_pkg::DATA_W-1:0]      divisor,
   output logic                             busy,
   output logic [sbli_pkg::DATA_W-1:0]      quotient
);
   import sbli_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   // remainder stays below the divisor, so 33 bits hold the trial value
   assign trial = {rem_ff, low_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[2*DATA_W-1:DATA_W];
         low_in  = dividend[DATA_W-1:0];
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign busy     = busy_ff;
   assign quotient = low_ff;

endmodule

/* rtl/sbli_ctrl.sv */
// Sequencing state machine: search, shift, read-out and divide steps per request.
// Depends on sbli_pkg; drives the datapath through cmd_type, reads stat_type.
module sbli_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sbli_pkg::stat_type  stat,
   output sbli_pkg::cmd_type   cmd
);
   import sbli_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_SRCH   = 4'd2;
   localparam logic [3:0] S_SCMP   = 4'd3;
   localparam logic [3:0] S_POST   = 4'd4;
   localparam logic [3:0] S_RD0    = 4'd5;
   localparam logic [3:0] S_RD1    = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_DSTART = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_MATCH  = 4'd11;
   localparam logic [3:0] S_SHUP   = 4'd12;
   localparam logic [3:0] S_INS    = 4'd13;
   localparam logic [3:0] S_SHDN   = 4'd14;
   localparam logic [3:0] S_RESP   = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            priority if (stat.op == OP_CLEAR) begin
               cmd.clr_cnt = 1'b1;
               state_in    = S_RESP;
            end else if (stat.op == OP_EVAL && stat.short_tbl) begin
               cmd.set_short = 1'b1;
               state_in      = S_RESP;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (stat.srch_done) begin
               state_in = S_POST;
            end else begin
               cmd.srch_rd = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RA_MID;
               state_in    = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = S_SRCH;
         end
         S_POST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_PREV;
            state_in   = (stat.op == OP_EVAL) ? S_RD0 : S_MATCH;
         end
         S_RD0: begin
            cmd.cap0 = 1'b1;
            if (stat.i_zero || stat.i_end) begin
               // query outside the table: clamp to the end value just read
               cmd.take_v0 = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_CUR;
               state_in   = S_RD1;
            end
         end
         S_RD1: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_RESP;
         end
         S_MATCH: begin
            if (stat.op == OP_INSERT) begin
               priority if (stat.match) begin
                  cmd.val_we = 1'b1;
                  cmd.wa_sel = WA_PREV;
                  state_in   = S_RESP;
               end else if (stat.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_RESP;
               end else if (stat.i_end) begin
                  cmd.key_we  = 1'b1;
                  cmd.val_we  = 1'b1;
                  cmd.wa_sel  = WA_CUR;
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = RA_TOP;
                  cmd.s_load_top = 1'b1;
                  state_in       = S_SHUP;
               end
            end else begin
               priority if (!stat.match) begin
                  state_in = S_RESP;
               end else if (stat.i_end) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = RA_CUR;
                  cmd.s_load_i = 1'b1;
                  state_in     = S_SHDN;
               end
            end
         end
         S_SHUP: begin
            // entry s moves up by one while entry s-1 is fetched
            cmd.key_we = 1'b1;
            cmd.val_we = 1'b1;
            cmd.wa_sel = WA_SUP;
            cmd.wd_mem = 1'b1;
            if (stat.s_at_i) begin
               state_in = S_INS;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_SDN;
               cmd.s_dec  = 1'b1;
            end
         end
         S_INS: begin
            cmd.key_we  = 1'b1;
            cmd.val_we  = 1'b1;
            cmd.wa_sel  = WA_CUR;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_SHDN: begin
            cmd.key_we = 1'b1;
            cmd.val_we = 1'b1;
            cmd.wa_sel = WA_SDN;
            cmd.wd_mem = 1'b1;
            if (stat.s_at_top) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_SUP;
               cmd.s_inc  = 1'b1;
            end
         end
         S_RESP: begin
            if (!stat.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* rtl/sbli_dp.sv */
// Datapath: breakpoint RAMs, search pointers, interpolation arithmetic, response register.
// Depends on sbli_pkg, sbli_ram and sbli_div; steered by sbli_ctrl commands.
module sbli_dp #(
   parameter int MAX_POINTS = sbli_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sbli_pkg::cmd_type                cmd,
   output sbli_pkg::stat_type               stat,
   input  logic [sbli_pkg::OP_W-1:0]        req_op,
   input  logic [sbli_pkg::DATA_W-1:0]      req_x,
   input  logic [sbli_pkg::DATA_W-1:0]      req_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sbli_pkg::DATA_W-1:0]      rsp_result,
   output logic [sbli_pkg::POINT_W-1:0]     rsp_count,
   output logic [sbli_pkg::STATUS_W-1:0]    rsp_status
);
   import sbli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [OP_W-1:0]     op_ff, op_in;
   logic [DATA_W-1:0]   x_ff, x_in;
   logic [DATA_W-1:0]   y_ff, y_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [AW-1:0]       mid_ff, mid_in;
   logic [AW-1:0]       s_ff, s_in;
   logic [DATA_W-1:0]   k0_ff, k0_in;
   logic [DATA_W-1:0]   v0_ff, v0_in;
   logic [DATA_W-1:0]   mag_ff, mag_in;
   logic [DATA_W-1:0]   dx_ff, dx_in;
   logic [DATA_W-1:0]   span_ff, span_in;
   logic                neg_ff, neg_in;
   logic [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_result_ff, rsp_result_in;
   logic [POINT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [DATA_W-1:0]   key_rdata, val_rdata;
   logic [DATA_W-1:0]   key_wdata, val_wdata;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [AW-1:0]       cur_addr, prev_addr, top_addr;
   logic [CW-1:0]       count_m1;
   logic [CW:0]         mid_sum;
   logic [DATA_W:0]     dy;
   logic [DATA_W:0]     dy_abs;
   logic                div_busy;
   logic [DATA_W-1:0]   quotient;
   logic                i_zero;

   assign count_m1  = count_ff - CW'(1);
   assign cur_addr  = lo_ff[AW-1:0];
   assign prev_addr = i_zero ? '0 : cur_addr - AW'(1);
   assign top_addr  = count_m1[AW-1:0];
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign i_zero    = (lo_ff == '0);

   always_comb begin
      unique case (cmd.rd_sel)
         RA_MID:  rd_addr = mid_sum[AW:1];
         RA_PREV: rd_addr = prev_addr;
         RA_CUR:  rd_addr = cur_addr;
         RA_SDN:  rd_addr = s_ff - AW'(1);
         RA_SUP:  rd_addr = s_ff + AW'(1);
         RA_TOP:  rd_addr = top_addr;
         default: rd_addr = cur_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wa_sel)
         WA_PREV: wr_addr = prev_addr;
         WA_CUR:  wr_addr = cur_addr;
         WA_SUP:  wr_addr = s_ff + AW'(1);
         WA_SDN:  wr_addr = s_ff - AW'(1);
         default: wr_addr = cur_addr;
      endcase
   end

   assign key_wdata = cmd.wd_mem ? key_rdata : x_ff;
   assign val_wdata = cmd.wd_mem ? val_rdata : y_ff;

   sbli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   sbli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (cmd.val_we),
      .wr_addr (wr_addr),
      .wr_data (val_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   sbli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign dy     = {val_rdata[DATA_W-1], val_rdata} - {v0_ff[DATA_W-1], v0_ff};
   assign dy_abs = dy[DATA_W] ? ((DATA_W+1)'(0) - dy) : dy;

   always_comb begin
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      s_in      = s_ff;
      k0_in     = k0_ff;
      v0_in     = v0_ff;
      mag_in    = mag_ff;
      dx_in     = dx_ff;
      span_in   = span_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      status_in = status_ff;

      if (cmd.load) begin
         op_in     = req_op;
         x_in      = req_x;
         y_in      = req_y;
         lo_in     = '0;
         hi_in     = count_ff;
         result_in = '0;
         status_in = STAT_DONE;
      end
      if (cmd.set_short) status_in = STAT_SHORT;
      if (cmd.set_full)  status_in = STAT_FULL;

      if (cmd.srch_rd) mid_in = mid_sum[AW:1];
      if (cmd.srch_cmp) begin
         if ($signed(key_rdata) <= $signed(x_ff)) begin
            lo_in = CW'(mid_ff) + CW'(1);
         end else begin
            hi_in = CW'(mid_ff);
         end
      end

      if (cmd.cap0) begin
         k0_in = key_rdata;
         v0_in = val_rdata;
      end
      if (cmd.take_v0) result_in = val_rdata;
      if (cmd.prep) begin
         // keys strictly increase and x0 <= x < x1, so these fit unsigned 32 bits
         span_in = key_rdata - k0_ff;
         dx_in   = x_ff - k0_ff;
         mag_in  = dy_abs[DATA_W-1:0];
         neg_in  = dy[DATA_W];
      end
      if (cmd.mul) prod_in = (2*DATA_W)'(mag_ff) * (2*DATA_W)'(dx_ff);
      if (cmd.fin) result_in = neg_ff ? (v0_ff - quotient) : (v0_ff + quotient);

      if (cmd.s_load_top) s_in = top_addr;
      if (cmd.s_load_i)   s_in = cur_addr;
      if (cmd.s_dec)      s_in = s_ff - AW'(1);
      if (cmd.s_inc)      s_in = s_ff + AW'(1);

      priority if (cmd.clr_cnt) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = result_ff;
         rsp_count_in  = POINT_W'(count_ff);
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      s_ff          <= s_in;
      k0_ff         <= k0_in;
      v0_ff         <= v0_in;
      mag_ff        <= mag_in;
      dx_ff         <= dx_in;
      span_ff       <= span_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      stat           = '0;
      stat.op        = op_ff;
      stat.short_tbl = (count_ff < CW'(2));
      stat.full      = (count_ff == CW'(MAX_POINTS));
      stat.srch_done = (lo_ff == hi_ff);
      stat.i_zero    = i_zero;
      stat.i_end     = (lo_ff == count_ff);
      stat.match     = !i_zero && (key_rdata == x_ff);
      stat.s_at_i    = (s_ff == cur_addr);
      stat.s_at_top  = (CW'(s_ff) == count_m1);
      stat.div_busy  = div_busy;
      stat.rsp_full  = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("breakpoint count above table size");

   a_no_full_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> count_ff < CW'(MAX_POINTS))
      else $error("count raised on a full table");

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> span_ff != '0)
      else $error("divide started with zero span");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_cmp |=> lo_ff <= hi_ff)
      else $error("search bounds crossed");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending response overwritten");

endmodule

/* rtl/sorted_breakpoint_linear_interp_unit.sv */
// Evaluate runs a binary search on the key RAM read port, then a bit-serial divider;
// insert/remove run the same search, then shift the entries past the index (up to n).
// One request in flight; the next is taken once the result sits in the output register.
// Reset (synchronous) empties the table and drops any pending result; RAMs are not cleared.
// Top level: joins sbli_ctrl and sbli_dp; uses sbli_pkg.
module sorted_breakpoint_linear_interp_unit #(
   parameter int MAX_POINTS = sbli_pkg::MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] x_value, [63:32] y_value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [38:32] point_count, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import sbli_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   logic [DATA_W-1:0]    rsp_result;
   logic [POINT_W-1:0]   rsp_count;

   sbli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbli_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_x      (req_tdata[31:0]),
      .req_y      (req_tdata[63:32]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_result};

endmodule
